// ===== rtl/core/mhpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap priority queue package
// Command and status codes and fixed field widths shared across the block.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int CMD_BITS    = 2;
   localparam int KEY_IN_BITS = 16;
   localparam int ID_BITS     = 24;
   localparam int STATUS_BITS = 2;

   localparam logic [CMD_BITS-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_POP  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_FIND = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd3;

endpackage

// ===== rtl/core/mhpq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap priority queue channels
// Valid/ready request and response channels of the queue.
// ----------------------------------------------------------------------------
interface mhpq_req_if;
   logic                                valid;
   logic                                ready;
   logic [mhpq_pkg::CMD_BITS-1:0]       command;
   logic [mhpq_pkg::KEY_IN_BITS-1:0]    key;
   logic [mhpq_pkg::ID_BITS-1:0]        entry_id;

   modport source (output valid, command, key, entry_id, input ready);
   modport sink   (input valid, command, key, entry_id, output ready);
endinterface

interface mhpq_rsp_if #(parameter int COUNT_BITS = 11);
   logic                                valid;
   logic                                ready;
   logic [mhpq_pkg::STATUS_BITS-1:0]    status;
   logic [mhpq_pkg::KEY_IN_BITS-1:0]    found_key;
   logic                                top_valid;
   logic [mhpq_pkg::KEY_IN_BITS-1:0]    top_key;
   logic [mhpq_pkg::ID_BITS-1:0]        top_id;
   logic [COUNT_BITS-1:0]               count;

   modport source (output valid, status, found_key, top_valid, top_key, top_id, count,
                   input ready);
   modport sink   (input valid, status, found_key, top_valid, top_key, top_id, count,
                   output ready);
endinterface

// ===== rtl/core/mhpq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 1024
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/core/min_heap_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap priority queue
// Array binary min-heap of (key, id) entries with push, pop and find by id.
// ----------------------------------------------------------------------------
// One item is taken at a time and all heap work runs through a single RAM
// port pair, one read per step. A push climbs level by level, reading each
// parent and moving it down while the new key is smaller. A pop sinks the
// hole level by level (read left, read right, move the winning child up),
// then fetches each later entry and lets it climb; a find scans slot by
// slot. Full pushes, empty pops and unused commands go straight to S_DONE.
// An unclaimed result waits in an output register; the next item may be taken.
module min_heap_priority_queue #(
   parameter int CAPACITY = 1024,
   parameter int KEY_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   mhpq_req_if.sink       req_chan,
   mhpq_rsp_if.source     rsp_chan
);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = AW + 2;
   localparam int KW = (KEY_BITS < mhpq_pkg::KEY_IN_BITS) ? KEY_BITS : mhpq_pkg::KEY_IN_BITS;
   localparam int EW = KW + mhpq_pkg::ID_BITS;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SU   = 4'd1;
   localparam logic [3:0] S_SC   = 4'd2;
   localparam logic [3:0] S_PL   = 4'd3;
   localparam logic [3:0] S_PR   = 4'd4;
   localparam logic [3:0] S_PC   = 4'd5;
   localparam logic [3:0] S_TR   = 4'd6;
   localparam logic [3:0] S_TL   = 4'd7;
   localparam logic [3:0] S_FR   = 4'd8;
   localparam logic [3:0] S_FC   = 4'd9;
   localparam logic [3:0] S_DONE = 4'd10;

   logic [3:0]                           state_ff, state_in;
   logic [mhpq_pkg::CMD_BITS-1:0]        cmd_ff, cmd_in;
   logic [EW-1:0]                        cur_ff, cur_in;
   logic [EW-1:0]                        left_ff, left_in;
   logic [EW-1:0]                        root_ff;
   logic [AW-1:0]                        pos_ff, pos_in;
   logic [AW-1:0]                        hole_ff, hole_in;
   logic [CW-1:0]                        scan_ff, scan_in;
   logic [CW-1:0]                        count_ff, count_in;
   logic [mhpq_pkg::STATUS_BITS-1:0]     status_ff, status_in;
   logic [KW-1:0]                        found_ff, found_in;

   logic                                 rsp_valid_ff;
   logic [mhpq_pkg::STATUS_BITS-1:0]     rsp_status_ff;
   logic [mhpq_pkg::KEY_IN_BITS-1:0]     rsp_found_ff;
   logic                                 rsp_top_valid_ff;
   logic [mhpq_pkg::KEY_IN_BITS-1:0]     rsp_top_key_ff;
   logic [mhpq_pkg::ID_BITS-1:0]         rsp_top_id_ff;
   logic [CW-1:0]                        rsp_count_ff;

   logic                                 wr_en;
   logic [AW-1:0]                        wr_addr;
   logic [EW-1:0]                        wr_data;
   logic [AW-1:0]                        rd_addr;
   logic [EW-1:0]                        rd_data;

   logic [AW-1:0]                        parent;
   logic [PW-1:0]                        left_idx;
   logic [PW-1:0]                        right_idx;
   logic [PW-1:0]                        count_w;
   logic                                 load_rsp;

   mhpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The searched id is held in the id part of the current entry register.
   function automatic logic [mhpq_pkg::ID_BITS-1:0] req_id_hold(input logic [EW-1:0] e);
      req_id_hold = e[mhpq_pkg::ID_BITS-1:0];
   endfunction

   assign parent    = AW'((pos_ff - AW'(1)) >> 1);
   assign left_idx  = {1'b0, hole_ff, 1'b1};
   assign right_idx = left_idx + PW'(1);
   assign count_w   = PW'(count_ff);
   assign load_rsp  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      cur_in    = cur_ff;
      left_in   = left_ff;
      pos_in    = pos_ff;
      hole_in   = hole_ff;
      scan_in   = scan_ff;
      count_in  = count_ff;
      status_in = status_ff;
      found_in  = found_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = cur_ff;
      rd_addr   = parent;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in    = req_chan.command;
               found_in  = '0;
               status_in = mhpq_pkg::STATUS_OK;
               state_in  = S_DONE;
               priority if (req_chan.command == mhpq_pkg::CMD_PUSH) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     status_in = mhpq_pkg::STATUS_FULL;
                  end else begin
                     pos_in   = count_ff[AW-1:0];
                     cur_in   = {req_chan.key[KW-1:0], req_chan.entry_id};
                     count_in = count_ff + CW'(1);
                     state_in = S_SU;
                  end
               end else if (req_chan.command == mhpq_pkg::CMD_POP) begin
                  if (count_ff == '0) begin
                     status_in = mhpq_pkg::STATUS_EMPTY;
                  end else begin
                     hole_in  = '0;
                     state_in = S_PL;
                  end
               end else if (req_chan.command == mhpq_pkg::CMD_FIND) begin
                  status_in = mhpq_pkg::STATUS_NOT_FOUND;
                  scan_in   = '0;
                  state_in  = S_FR;
               end else begin
                  // An unused command only reports the top entry and count.
                  state_in = S_DONE;
               end
            end
         end
         S_SU: begin
            if (pos_ff == '0) begin
               wr_en = 1'b1;
               if (cmd_ff == mhpq_pkg::CMD_POP) begin
                  scan_in  = scan_ff + CW'(1);
                  state_in = S_TR;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_SC;
            end
         end
         S_SC: begin
            wr_en = 1'b1;
            if (cur_ff[EW-1:mhpq_pkg::ID_BITS] < rd_data[EW-1:mhpq_pkg::ID_BITS]) begin
               // Parent moves down and the entry keeps climbing.
               wr_data  = rd_data;
               pos_in   = parent;
               state_in = S_SU;
            end else if (cmd_ff == mhpq_pkg::CMD_POP) begin
               scan_in  = scan_ff + CW'(1);
               state_in = S_TR;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PL: begin
            rd_addr = left_idx[AW-1:0];
            if (left_idx >= count_w) begin
               scan_in  = CW'(hole_ff) + CW'(1);
               state_in = S_TR;
            end else begin
               state_in = S_PR;
            end
         end
         S_PR: begin
            left_in = rd_data;
            rd_addr = right_idx[AW-1:0];
            if (right_idx < count_w) begin
               state_in = S_PC;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = hole_ff;
               wr_data  = rd_data;
               hole_in  = left_idx[AW-1:0];
               state_in = S_PL;
            end
         end
         S_PC: begin
            wr_en   = 1'b1;
            wr_addr = hole_ff;
            // The left child wins only when strictly smaller.
            if (left_ff[EW-1:mhpq_pkg::ID_BITS] < rd_data[EW-1:mhpq_pkg::ID_BITS]) begin
               wr_data = left_ff;
               hole_in = left_idx[AW-1:0];
            end else begin
               wr_data = rd_data;
               hole_in = right_idx[AW-1:0];
            end
            state_in = S_PL;
         end
         S_TR: begin
            rd_addr = scan_ff[AW-1:0];
            if (scan_ff >= count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end else begin
               state_in = S_TL;
            end
         end
         S_TL: begin
            cur_in   = rd_data;
            pos_in   = AW'(scan_ff - CW'(1));
            state_in = S_SU;
         end
         S_FR: begin
            rd_addr = scan_ff[AW-1:0];
            if (scan_ff >= count_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_FC;
            end
         end
         S_FC: begin
            if (rd_data[mhpq_pkg::ID_BITS-1:0] == req_id_hold(cur_ff)) begin
               found_in  = rd_data[EW-1:mhpq_pkg::ID_BITS];
               status_in = mhpq_pkg::STATUS_OK;
               state_in  = S_DONE;
            end else begin
               scan_in  = scan_ff + CW'(1);
               state_in = S_FR;
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      left_ff   <= left_in;
      pos_ff    <= pos_in;
      hole_ff   <= hole_in;
      scan_ff   <= scan_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      if (state_ff == S_IDLE && req_chan.valid && req_chan.command == mhpq_pkg::CMD_FIND) begin
         cur_ff <= {{KW{1'b0}}, req_chan.entry_id};
      end else begin
         cur_ff <= cur_in;
      end
      if (wr_en && wr_addr == '0) begin
         root_ff <= wr_data;
      end
      if (load_rsp) begin
         rsp_status_ff    <= status_ff;
         rsp_found_ff     <= mhpq_pkg::KEY_IN_BITS'(found_ff);
         rsp_count_ff     <= count_ff;
         rsp_top_valid_ff <= (count_ff != '0);
         if (count_ff != '0) begin
            rsp_top_key_ff <= mhpq_pkg::KEY_IN_BITS'(root_ff[EW-1:mhpq_pkg::ID_BITS]);
            rsp_top_id_ff  <= root_ff[mhpq_pkg::ID_BITS-1:0];
         end else begin
            rsp_top_key_ff <= '0;
            rsp_top_id_ff  <= '0;
         end
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.found_key = rsp_found_ff;
   assign rsp_chan.top_valid = rsp_top_valid_ff;
   assign rsp_chan.top_key   = rsp_top_key_ff;
   assign rsp_chan.top_id    = rsp_top_id_ff;
   assign rsp_chan.count     = rsp_count_ff;
endmodule

// ===== rtl/core/mhpq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap priority queue checker
// Port-level properties of the queue, attached to the top level by bind.
// ----------------------------------------------------------------------------
module mhpq_port_checker #(
   parameter int CW = 11
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [mhpq_pkg::STATUS_BITS-1:0]   rsp_status,
   input logic                               rsp_top_valid,
   input logic [mhpq_pkg::KEY_IN_BITS-1:0]   rsp_top_key,
   input logic [CW-1:0]                      rsp_count
);
   // A held response keeps its status and count.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count))
      else $error("response changed while stalled");

   // Only one item is in work at a time.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while busy");

   a_top_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_top_valid == (rsp_count != '0)))
      else $error("top flag disagrees with count");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mhpq_pkg::STATUS_EMPTY |-> rsp_count == '0)
      else $error("empty pop reported with entries held");

   a_empty_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_top_valid |-> rsp_top_key == '0)
      else $error("empty heap shows a top key");
endmodule

bind min_heap_priority_queue mhpq_port_checker #(.CW(CW)) u_mhpq_port_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_status    (rsp_chan.status),
   .rsp_top_valid (rsp_chan.top_valid),
   .rsp_top_key   (rsp_chan.top_key),
   .rsp_count     (rsp_chan.count)
);
